/* src/aprb_pkg.sv */
package aprb_pkg;

  // Ring depth; a power of two so slot arithmetic wraps by truncation.
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned SlotW    = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW     = 16;

  localparam int unsigned KindW    = 3;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned DtW      = 20;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned MaxPtsW  = 8;
  localparam int unsigned LifeW    = 21;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 21;

  localparam logic [MaxPtsW-1:0] MaxPtsReset = MaxPtsW'(128);
  localparam logic [LifeW-1:0]   LifeReset   = LifeW'(65536);

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 3'd0,
    KIND_AGE    = 3'd1,
    KIND_EXPIRE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_POINTS = 1'b0,
    CFG_LIFETIME   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_AGE,
    ST_EXP_RD,
    ST_EXP_CHK
  } state_e;

endpackage

/* src/aging_point_ring_buffer.sv */
// Aging point ring buffer: a ring of 3-D Q16.16 points with ages, oldest at
// head. One item on the input channel (in_valid_i / in_stall_o) carries an
// operation: add, age, expire, clear or read. Each item yields exactly one
// result item on the output channel (out_valid_o / out_stall_i) with the
// point count after the operation and, for a read, the point and its age.
// Add, clear and unused kinds load the result register directly; a read
// first takes one registered memory read. For age, the shared saturating
// adder walks one point per cycle through the age memory (read, then
// write back). Expire makes one head compare per cycle, popping expired
// points from the head.
// The block takes one item at a time: in_stall_o is high while an operation
// runs and while a result sits in the output register. A stall on the
// output simply holds the result; nothing is lost.
// Reset empties the ring (head and count zero) and loads max_points 128 and
// lifetime 1.0 s. The point memories are not cleared; entries are only read
// after being written. The user must see that configuration is written
// through cfg_we_i only while idle; the block does not enforce it.
module aging_point_ring_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aprb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aprb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [aprb_pkg::KindW-1:0]     kind_i,
  input  logic signed [aprb_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [aprb_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [aprb_pkg::CoordW-1:0] pos_z_i,
  input  logic [aprb_pkg::DtW-1:0]       dt_i,
  input  logic [aprb_pkg::IdxW-1:0]      index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [aprb_pkg::CntW-1:0]      point_count_o,
  output logic                           read_valid_o,
  output logic signed [aprb_pkg::CoordW-1:0] out_x_o,
  output logic signed [aprb_pkg::CoordW-1:0] out_y_o,
  output logic signed [aprb_pkg::CoordW-1:0] out_z_o,
  output logic [aprb_pkg::AgeW-1:0]      out_age_o
);
  import aprb_pkg::*;

  // Configuration registers
  logic [MaxPtsW-1:0] max_points_q;
  logic [LifeW-1:0]   lifetime_q;

  // Ring control
  state_e             state_q, state_d;
  logic [SlotW-1:0]   head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    walk_q, walk_d;       // age walk read offset
  logic               wb_valid_q, wb_valid_d; // age write-back pending
  logic [SlotW-1:0]   wb_addr_q, wb_addr_d;

  // Latched operands
  logic [DtW-1:0]     dt_q;
  logic [IdxW-1:0]    idx_q;

  // Point memories
  logic [CoordW-1:0]  mem_x   [CAPACITY];
  logic [CoordW-1:0]  mem_y   [CAPACITY];
  logic [CoordW-1:0]  mem_z   [CAPACITY];
  logic [AgeW-1:0]    mem_age [CAPACITY];

  logic [SlotW-1:0]   raddr;
  logic [CoordW-1:0]  rd_x_q, rd_y_q, rd_z_q;
  logic [AgeW-1:0]    rd_age_q;

  logic               we_pos, we_age;
  logic [SlotW-1:0]   waddr;
  logic [AgeW-1:0]    wage;

  // Output register
  logic               out_valid_q;
  logic [CntW-1:0]    out_count_q;
  logic               out_rv_q;
  logic [CoordW-1:0]  out_x_q, out_y_q, out_z_q;
  logic [AgeW-1:0]    out_age_q;

  logic               res_load, res_rv;
  logic               in_acc;
  logic [CmpW-1:0]    limit;
  logic [AgeW:0]      age_sum;
  logic               rd_hit;

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Add limit: max_points clamped to 1..CAPACITY
  always_comb begin
    limit = CmpW'(max_points_q);
    if (limit == '0) begin
      limit = CmpW'(1);
    end else if (limit > CmpW'(CAPACITY)) begin
      limit = CmpW'(CAPACITY);
    end
  end

  // Shared saturating adder for the age walk
  assign age_sum = {1'b0, rd_age_q} + (AgeW + 1)'(dt_q);
  assign rd_hit  = CmpW'(idx_q) < CmpW'(count_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    walk_d     = walk_q;
    wb_valid_d = 1'b0;
    wb_addr_d  = wb_addr_q;
    raddr      = head_q + SlotW'(index_i);
    we_pos     = 1'b0;
    we_age     = 1'b0;
    waddr      = head_q + SlotW'(count_q);
    wage       = '0;
    res_load   = 1'b0;
    res_rv     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            KIND_ADD: begin
              we_pos = 1'b1;
              we_age = 1'b1;
              if (CmpW'(count_q) < limit) begin
                count_d = count_q + CntW'(1);
              end else begin
                head_d = head_q + SlotW'(1);
                waddr  = head_q + SlotW'(limit);
              end
              res_load = 1'b1;
            end
            KIND_AGE: begin
              walk_d  = '0;
              state_d = ST_AGE;
            end
            KIND_EXPIRE: state_d = ST_EXP_RD;
            KIND_CLEAR: begin
              count_d  = '0;
              head_d   = '0;
              res_load = 1'b1;
            end
            KIND_READ: state_d = ST_READ;
            default:   res_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_rv   = rd_hit;
        state_d  = ST_IDLE;
      end
      ST_AGE: begin
        // write back the point read last cycle
        if (wb_valid_q) begin
          we_age = 1'b1;
          waddr  = wb_addr_q;
          wage   = age_sum[AgeW] ? '1 : age_sum[AgeW-1:0];
        end
        if (walk_q < count_q) begin
          raddr      = head_q + SlotW'(walk_q);
          walk_d     = walk_q + CntW'(1);
          wb_valid_d = 1'b1;
          wb_addr_d  = head_q + SlotW'(walk_q);
        end else if (!wb_valid_q) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_EXP_RD: begin
        raddr   = head_q;
        state_d = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        // rd_age_q is the age at head; prefetch the next slot
        raddr = head_q + SlotW'(1);
        if (count_q != '0 && rd_age_q > AgeW'(lifetime_q)) begin
          head_d  = head_q + SlotW'(1);
          count_d = count_q - CntW'(1);
        end else begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_pos) begin
      mem_x[waddr] <= pos_x_i;
      mem_y[waddr] <= pos_y_i;
      mem_z[waddr] <= pos_z_i;
    end
    if (we_age) begin
      mem_age[waddr] <= wage;
    end
    rd_x_q   <= mem_x[raddr];
    rd_y_q   <= mem_y[raddr];
    rd_z_q   <= mem_z[raddr];
    rd_age_q <= mem_age[raddr];
  end

  // Operand latches
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q  <= dt_i;
      idx_q <= index_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      walk_q     <= '0;
      wb_valid_q <= 1'b0;
      wb_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      walk_q     <= walk_d;
      wb_valid_q <= wb_valid_d;
      wb_addr_q  <= wb_addr_d;
    end
  end

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_points_q <= MaxPtsReset;
      lifetime_q   <= LifeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MAX_POINTS: max_points_q <= cfg_data_i[MaxPtsW-1:0];
        CFG_LIFETIME:   lifetime_q   <= cfg_data_i[LifeW-1:0];
        default:        ;
      endcase
    end
  end

  // Result register; fields other than the count are zero unless a read hits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_count_q <= count_d;
      out_rv_q    <= res_rv;
      out_x_q     <= res_rv ? rd_x_q   : '0;
      out_y_q     <= res_rv ? rd_y_q   : '0;
      out_z_q     <= res_rv ? rd_z_q   : '0;
      out_age_q   <= res_rv ? rd_age_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_count_o = out_count_q;
  assign read_valid_o  = out_rv_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign out_age_o     = out_age_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

// Self-checking bench for the aging point ring buffer.
// Every accepted input item is run through a local shadow of the ring (same
// head/count rules, same saturating age add, same clamped max_points) and the
// resulting status item is queued; every output item is compared field by
// field against the oldest queued status.
module testbench;
  import aprb_pkg::*;

  localparam int unsigned HoldLen = 400;  // long output hold-off for pressure
  localparam int unsigned KindTop = (1 << KindW) - 1;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [DtW-1:0]           dt;
    logic [IdxW-1:0]          idx;
  } ring_op_t;

  typedef struct packed {
    logic [CntW-1:0]          count;
    logic                     hit;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [AgeW-1:0]          age;
  } ring_status_t;

  // DUT-facing signals; every input has a known value from time zero
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [KindW-1:0]         kind_i = '0;
  logic signed [CoordW-1:0] pos_x_i = '0;
  logic signed [CoordW-1:0] pos_y_i = '0;
  logic signed [CoordW-1:0] pos_z_i = '0;
  logic [DtW-1:0]           dt_i = '0;
  logic [IdxW-1:0]          index_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [CntW-1:0]          point_count_o;
  logic                     read_valid_o;
  logic signed [CoordW-1:0] out_x_o;
  logic signed [CoordW-1:0] out_y_o;
  logic signed [CoordW-1:0] out_z_o;
  logic [AgeW-1:0]          out_age_o;

  aging_point_ring_buffer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .dt_i         (dt_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_count_o(point_count_o),
    .read_valid_o (read_valid_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_age_o    (out_age_o)
  );

  // Shadow ring: point store, head/count and the two config registers
  logic [CoordW-1:0] mem_x   [CAPACITY] = '{default: '0};
  logic [CoordW-1:0] mem_y   [CAPACITY] = '{default: '0};
  logic [CoordW-1:0] mem_z   [CAPACITY] = '{default: '0};
  logic [AgeW-1:0]   mem_age [CAPACITY] = '{default: '0};
  int unsigned       ring_head = 0;
  int unsigned       ring_fill = 0;
  int unsigned       keep_max  = MaxPtsReset;
  int unsigned       life_max  = LifeReset;

  ring_op_t     ops_to_send [$];
  ring_status_t pending_results [$];
  ring_op_t     cur_op;
  ring_status_t want;

  int          n_sent = 0;   // items queued by the stimulus
  int          n_done = 0;   // result items taken by the monitor
  int          n_fail = 0;
  int          tx_pct = 0;   // sender idle chance, percent
  int          rx_pct = 0;   // receiver stall chance, percent
  bit          press_on = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // max_points as the ring uses it: 0 and 1 both mean one point, above
  // CAPACITY means CAPACITY
  function automatic int unsigned keep_limit(input int unsigned mp);
    if (mp < 1) return 1;
    if (mp > CAPACITY) return CAPACITY;
    return mp;
  endfunction

  // Applies one operation to the shadow ring, returns the status item
  function automatic ring_status_t ring_apply(input ring_op_t op);
    ring_status_t st;
    int unsigned  limit;
    int unsigned  slot;
    int unsigned  i;
    logic [AgeW:0] sum;
    st = '0;
    case (op.kind)
      KIND_ADD: begin
        limit = keep_limit(keep_max);
        if (ring_fill < limit) begin
          slot = (ring_head + ring_fill) % CAPACITY;
          ring_fill++;
        end else begin
          // full (or limit lowered below fill): drop oldest, count unchanged
          ring_head = (ring_head + 1) % CAPACITY;
          slot = (ring_head + limit - 1) % CAPACITY;
        end
        mem_x[slot] = op.x;
        mem_y[slot] = op.y;
        mem_z[slot] = op.z;
        mem_age[slot] = '0;
      end
      KIND_AGE: begin
        for (i = 0; i < ring_fill; i++) begin
          slot = (ring_head + i) % CAPACITY;
          sum = {1'b0, mem_age[slot]} + op.dt;
          mem_age[slot] = sum[AgeW] ? '1 : sum[AgeW-1:0];
        end
      end
      KIND_EXPIRE: begin
        // strictly above lifetime; equal survives
        while (ring_fill > 0 && mem_age[ring_head] > life_max) begin
          ring_head = (ring_head + 1) % CAPACITY;
          ring_fill--;
        end
      end
      KIND_CLEAR: begin
        ring_fill = 0;
        ring_head = 0;
      end
      KIND_READ: begin
        if (op.idx < ring_fill) begin
          slot = (ring_head + op.idx) % CAPACITY;
          st.hit = 1'b1;
          st.x = mem_x[slot];
          st.y = mem_y[slot];
          st.z = mem_z[slot];
          st.age = mem_age[slot];
        end
      end
      default: ;  // unused kinds only report the count
    endcase
    st.count = CntW'(ring_fill);
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Random field helpers; extremes come up often
  // ---------------------------------------------------------------------
  function automatic logic [CoordW-1:0] rnd_coord();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(CoordW-1){1'b0}}};
      1: return {1'b0, {(CoordW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // dt scaled to the lifetime so that expiry actually happens
  function automatic logic [DtW-1:0] rnd_dt();
    int unsigned cap;
    cap = life_max / 3 + 1;
    if (cap > (1 << DtW) - 1) cap = (1 << DtW) - 1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return DtW'($urandom_range(0, cap));
      default: return DtW'($urandom);
    endcase
  endfunction

  // mostly within the kept range, sometimes anywhere
  function automatic logic [IdxW-1:0] rnd_index();
    int unsigned top;
    top = keep_limit(keep_max);
    if (top > CAPACITY - 1) top = CAPACITY - 1;
    if (roll(75)) return IdxW'($urandom_range(0, top));
    return IdxW'($urandom);
  endfunction

  function automatic logic [KindW-1:0] rnd_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return KIND_ADD;
    if (r < 50) return KIND_AGE;
    if (r < 64) return KIND_EXPIRE;
    if (r < 93) return KIND_READ;
    if (r < 96) return KIND_CLEAR;
    return KindW'($urandom_range(KIND_READ + 1, KindTop));
  endfunction

  // fields the operation does not use are still random
  function automatic ring_op_t rnd_op(input logic [KindW-1:0] kind);
    ring_op_t op;
    op.kind = kind;
    op.x = rnd_coord();
    op.y = rnd_coord();
    op.z = rnd_coord();
    op.dt = rnd_dt();
    op.idx = rnd_index();
    return op;
  endfunction

  task automatic queue_op(input ring_op_t op);
    ops_to_send.push_back(op);
    n_sent++;
  endtask

  task automatic cfg_write(input cfg_reg_e which, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= val;
    case (which)
      CFG_MAX_POINTS: keep_max = val[MaxPtsW-1:0];
      CFG_LIFETIME:   life_max = val[LifeW-1:0];
      default: ;
    endcase
  endtask

  // every queued item has come back as a result; block is idle
  task automatic wait_drained();
    while (n_done != n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One random phase: config, idling profile, then bursts of adds followed
  // by mixed operations, ending with a few adds so the next phase can start
  // with a count above a lowered max_points.
  task automatic run_phase(input int unsigned mp, input int unsigned life,
                           input int tx, input int rx, input int n, input bit press);
    int made;
    int burst;
    int k;
    int unsigned lim;
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);  // upper bits are don't-care for max_points
    word[MaxPtsW-1:0] = mp[MaxPtsW-1:0];
    cfg_write(CFG_MAX_POINTS, word);
    cfg_write(CFG_LIFETIME, CfgDataW'(life));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tx_pct = tx;
    rx_pct = rx;
    press_on = press;
    lim = keep_limit(mp[MaxPtsW-1:0]);
    made = 0;
    while (made < n) begin
      burst = roll(25) ? $urandom_range(1, lim + 2) : $urandom_range(1, 8);
      for (k = 0; k < burst && made < n; k++) begin
        queue_op(rnd_op(KIND_ADD));
        made++;
      end
      burst = $urandom_range(4, 24);
      for (k = 0; k < burst && made < n; k++) begin
        queue_op(rnd_op(rnd_kind()));
        made++;
      end
    end
    burst = $urandom_range(0, 12);
    for (k = 0; k < burst; k++) queue_op(rnd_op(KIND_ADD));
    wait_drained();
    press_on = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [AgeW-1:0] exp_v,
                             input logic [AgeW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Driver: takes items from ops_to_send; a stalled item stays put. The
  // shadow ring is updated at the edge where the DUT accepts the item.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_results.push_back(ring_apply(cur_op));
      if (!in_valid_i || !in_stall_o) begin
        if (ops_to_send.size() != 0 && !roll(tx_pct)) begin
          cur_op = ops_to_send.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= cur_op.kind;
          pos_x_i <= cur_op.x;
          pos_y_i <= cur_op.y;
          pos_z_i <= cur_op.z;
          dt_i <= cur_op.dt;
          index_i <= cur_op.idx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter for the pressure phases; while it runs the output
  // stays stalled and the input channel backs up behind it.
  always @(posedge clk_i) begin
    if (!press_on) begin
      hold_cycles <= 0;
    end else if (hold_cycles < HoldLen) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each taken result item with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_done++;
        if (pending_results.size() == 0) begin
          $error("result item with no expectation: count %0d", point_count_o);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          check_field("point_count", AgeW'(want.count), AgeW'(point_count_o));
          check_field("read_valid", AgeW'(want.hit), AgeW'(read_valid_o));
          check_field("out_x", want.x, out_x_o);
          check_field("out_y", want.y, out_y_o);
          check_field("out_z", want.z, out_z_o);
          check_field("out_age", want.age, out_age_o);
        end
      end
      out_stall_i <= (press_on && hold_cycles < HoldLen) || roll(rx_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    ring_op_t op;
    int k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every slot once at reset config; from here on no read or age
    // can land on a slot that was never written.
    for (k = 0; k < CAPACITY; k++) queue_op(rnd_op(KIND_ADD));
    wait_drained();

    // Directed: ring full at 128, lifetime 1.0
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);
    op = rnd_op(KIND_READ); op.idx = '1; queue_op(op);
    // add while full: oldest dropped, count stays
    op = rnd_op(KIND_ADD);
    op.x = {1'b1, {(CoordW-1){1'b0}}};
    op.y = {1'b0, {(CoordW-1){1'b1}}};
    op.z = '1;
    queue_op(op);
    op = rnd_op(KIND_READ); op.idx = '1; queue_op(op);
    op = rnd_op(KIND_AGE); op.dt = '1; queue_op(op);
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);
    op = rnd_op(KIND_AGE); op.dt = '0; queue_op(op);
    op = rnd_op(KIND_EXPIRE); queue_op(op);       // everything is past 1.0
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);   // empty: out of range
    op = rnd_op(KIND_READ); op.idx = '1; queue_op(op);
    for (k = KIND_READ + 1; k <= KindTop; k++) queue_op(rnd_op(KindW'(k)));
    op = rnd_op(KIND_CLEAR); queue_op(op);
    op = rnd_op(KIND_ADD);
    op.x = {1'b0, {(CoordW-1){1'b1}}};
    op.y = '0;
    op.z = {1'b1, {(CoordW-1){1'b0}}};
    queue_op(op);
    queue_op(rnd_op(KIND_ADD));
    op = rnd_op(KIND_READ); op.idx = IdxW'(1); queue_op(op);
    op = rnd_op(KIND_READ); op.idx = IdxW'(2); queue_op(op);   // just past count
    // age exactly to lifetime: not expired; one more tick: expired
    op = rnd_op(KIND_AGE); op.dt = DtW'(LifeReset); queue_op(op);
    queue_op(rnd_op(KIND_EXPIRE));
    op = rnd_op(KIND_AGE); op.dt = DtW'(1); queue_op(op);
    queue_op(rnd_op(KIND_EXPIRE));
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);
    wait_drained();

    // Random phases: max_points extremes (0, 1, 2, 255), lifetime 0 and
    // max, each idling profile, two with a long output hold-off
    run_phase(128, 65536, 0, 0, 150, 1'b1);
    run_phase(2, 0, 76, 0, 150, 1'b0);
    run_phase(255, 2097151, 0, 76, 150, 1'b0);
    run_phase(0, $urandom_range(0, 2097151), 16, 16, 150, 1'b0);
    run_phase(1, $urandom_range(0, 4096), 0, 0, 150, 1'b1);
    run_phase($urandom_range(2, 128), $urandom_range(0, 2097151), 76, 0, 150, 1'b0);
    run_phase(7, 131072, 0, 76, 150, 1'b0);
    run_phase(128, $urandom_range(0, 2097151), 16, 16, 100, 1'b0);

    // Long aging run: two points aged mostly by the largest dt, then
    // expired at the largest lifetime
    cfg_write(CFG_MAX_POINTS, CfgDataW'(2));
    cfg_write(CFG_LIFETIME, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tx_pct = 16;
    rx_pct = 16;
    queue_op(rnd_op(KIND_CLEAR));
    queue_op(rnd_op(KIND_ADD));
    queue_op(rnd_op(KIND_ADD));
    for (k = 0; k < 40; k++) begin
      op = rnd_op(KIND_AGE);
      if (!roll(10)) op.dt = '1;
      queue_op(op);
      if (k % 16 == 0) begin
        op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);
      end
    end
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);
    op = rnd_op(KIND_READ); op.idx = IdxW'(1); queue_op(op);
    queue_op(rnd_op(KIND_EXPIRE));
    op = rnd_op(KIND_READ); op.idx = '0; queue_op(op);

    wait_drained();
    repeat (140) @(posedge clk_i);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #(40_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* aging_point_ring_buffer.f */
src/aprb_pkg.sv
src/aging_point_ring_buffer.sv
tb/sv/testbench.sv
